[rtl/mmb64_pkg.sv]
package mmb64_pkg;

  localparam int unsigned MaxSamplesDefault = 32;
  localparam int unsigned CountW = 6;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               line_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] byte_kind;
    logic       final_byte;
  } out_item_t;

  localparam logic [1:0] KindCount  = 2'd0;
  localparam logic [1:0] KindLength = 2'd1;
  localparam logic [1:0] KindText   = 2'd2;

  localparam logic [7:0] PadChar = 8'h3D;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;        // store sample, update min/max
    logic clear;       // return line state to reset values
    logic rd_en;       // read sample at rd_addr
    logic div_start;   // begin scaling of the read sample
    logic zero_byte;   // missing sample of a short group
    logic grp_clr;     // clear the group byte registers
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] c;
    if (idx < 6'd26) begin
      c = 8'h41 + {2'b00, idx};
    end else if (idx < 6'd52) begin
      c = 8'h61 + {2'b00, idx - 6'd26};
    end else if (idx < 6'd62) begin
      c = 8'h30 + {2'b00, idx - 6'd52};
    end else if (idx == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

[rtl/mmb64_datapath.sv]
module mmb64_datapath
  import mmb64_pkg::*;
#(
  parameter int unsigned MaxSamples = MaxSamplesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  input  logic signed [31:0] sample_i,
  input  logic [CountW-1:0]  wr_addr_i,
  input  logic [CountW-1:0]  rd_addr_i,
  input  logic [1:0]         slot_i,
  output dp_sts_t            sts_o,
  output logic [23:0]        group_o
);

  localparam int unsigned AddrW = (MaxSamples > 1) ? $clog2(MaxSamples) : 1;

  logic signed [31:0] mem_q [MaxSamples];
  logic signed [31:0] rd_q;
  logic signed [31:0] min_q, max_q;
  logic [23:0]        grp_q;

  // restoring divider: (off << 8) / range, 9 quotient bits
  logic [32:0] range_w;
  logic [32:0] rem_q;
  logic [32:0] dvs_q;
  logic [8:0]  quo_q;
  logic [3:0]  step_q;
  logic        busy_q, flat_q, done_q;
  logic [33:0] trial;
  logic [7:0]  qbyte;

  assign range_w = 33'(max_q) - 33'(min_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (wr_addr_i < CountW'(MaxSamples))) begin
      mem_q[wr_addr_i[AddrW-1:0]] <= sample_i;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= 32'sh7FFFFFFF;
      max_q <= 32'sh80000000;
    end else if (cmd_i.clear) begin
      min_q <= 32'sh7FFFFFFF;
      max_q <= 32'sh80000000;
    end else if (cmd_i.load && (wr_addr_i < CountW'(MaxSamples))) begin
      if (sample_i < min_q) min_q <= sample_i;
      if (sample_i > max_q) max_q <= sample_i;
    end
  end

  assign trial = {rem_q, 1'b0} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.div_start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 4'd1;
        if (step_q == 4'd8) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // payload side of the divider
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q  <= 33'(rd_q) - 33'(min_q);
      dvs_q  <= range_w;
      flat_q <= (range_w == '0);
      quo_q  <= '0;
    end else if (busy_q) begin
      // off < range*2 after one shift; off <= range so quotient fits 9 bits
      if (step_q == 4'd0) begin
        // first bit compares off against range without shift
        if ({1'b0, rem_q} >= {1'b0, dvs_q}) begin
          rem_q <= rem_q - dvs_q;
          quo_q <= 9'd1;
        end
      end else if (!trial[33]) begin
        rem_q <= trial[32:0];
        quo_q <= {quo_q[7:0], 1'b1};
      end else begin
        rem_q <= {rem_q[31:0], 1'b0};
        quo_q <= {quo_q[7:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (flat_q) qbyte = 8'h00;
    else if (quo_q[8]) qbyte = 8'hFF;
    else qbyte = quo_q[7:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grp_clr) begin
      grp_q <= '0;
    end else if (done_q || cmd_i.zero_byte) begin
      unique case (slot_i)
        2'd0:    grp_q[23:16] <= done_q ? (qbyte ^ 8'h80) : 8'h00;
        2'd1:    grp_q[15:8]  <= done_q ? (qbyte ^ 8'h80) : 8'h00;
        default: grp_q[7:0]   <= done_q ? (qbyte ^ 8'h80) : 8'h00;
      endcase
    end
  end

  assign sts_o.div_done = done_q;
  assign group_o = grp_q;

endmodule

[rtl/mmb64_ctrl.sv]
module mmb64_ctrl
  import mmb64_pkg::*;
#(
  parameter int unsigned MaxSamples = MaxSamplesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              line_end_i,
  input  dp_sts_t           sts_i,
  input  logic [23:0]       group_i,
  output logic              busy_o,
  output dp_cmd_t           cmd_o,
  output logic [CountW-1:0] wr_addr_o,
  output logic [CountW-1:0] rd_addr_o,
  output logic [1:0]        slot_o,
  output logic              valid_o,
  output out_item_t         item_o
);

  typedef enum logic [2:0] {
    StIdle, StCount, StLen, StRead, StDiv, StChar
  } state_e;

  state_e            state_q;
  logic [CountW-1:0] cnt_q, idx_q;
  logic              ovf_q;
  logic [1:0]        slot_q, ch_q;
  logic              valid_q;
  out_item_t         item_q;
  logic [7:0]        len_w;
  logic [CountW-1:0] grp_base;
  logic              has1, has2, last_grp;
  logic [5:0]        cidx;
  logic [7:0]        ch_byte;
  logic              accept;

  assign accept = start_i && (state_q == StIdle);
  assign busy_o = (state_q != StIdle);

  // 4*ceil(n/3) for n <= 63 via small multiply by reciprocal
  always_comb begin
    logic [13:0] t;
    t = (14'(cnt_q) + 14'd2) * 14'd171;
    len_w = 8'({t[13:9], 2'b00});
  end

  // text is emitted after all three slots are read, so idx_q already points
  // at the next group
  assign grp_base = idx_q - CountW'(3);
  assign has1     = (CountW'(grp_base + 1'b1) < cnt_q);
  assign has2     = (CountW'(grp_base + 2'd2) < cnt_q);
  assign last_grp = (CountW'(grp_base + 2'd3) >= cnt_q);

  always_comb begin
    unique case (ch_q)
      2'd0: cidx = group_i[23:18];
      2'd1: cidx = group_i[17:12];
      2'd2: cidx = group_i[11:6];
      default: cidx = group_i[5:0];
    endcase
    ch_byte = b64_char(cidx);
    if ((ch_q == 2'd2) && !has1) ch_byte = PadChar;
    if ((ch_q == 2'd3) && !has2) ch_byte = PadChar;
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.load  = accept;
    cmd_o.clear = (state_q == StChar) && (ch_q == 2'd3) && last_grp;
    if (accept && line_end_i && (ovf_q || (cnt_q >= CountW'(MaxSamples)))) begin
      cmd_o.clear = 1'b1;
    end
    cmd_o.rd_en     = (state_q == StRead) && (idx_q < cnt_q);
    cmd_o.zero_byte = (state_q == StRead) && (idx_q >= cnt_q);
    cmd_o.div_start = (state_q == StDiv) && !valid_q && !sts_i.div_done
                      && (idx_q < cnt_q) && (ch_q == 2'd1);
    cmd_o.grp_clr   = 1'b0;
  end

  assign wr_addr_o = cnt_q;
  assign rd_addr_o = idx_q;
  assign slot_o    = slot_q;
  assign valid_o   = valid_q;
  assign item_o    = item_q;

  // ch_q doubles as a sub-step marker in StDiv: 0 wait read, 1 start, 2 wait done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      idx_q   <= '0;
      ovf_q   <= 1'b0;
      slot_q  <= '0;
      ch_q    <= '0;
      valid_q <= 1'b0;
      item_q  <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            if (cnt_q < CountW'(MaxSamples)) cnt_q <= cnt_q + 1'b1;
            else ovf_q <= 1'b1;
            if (line_end_i) begin
              if (ovf_q || (cnt_q >= CountW'(MaxSamples))) begin
                cnt_q <= '0;
                ovf_q <= 1'b0;
              end else begin
                state_q <= StCount;
              end
            end
          end
        end
        StCount: begin
          valid_q <= 1'b1;
          item_q  <= '{out_byte: 8'(cnt_q), byte_kind: KindCount, final_byte: 1'b0};
          state_q <= StLen;
        end
        StLen: begin
          valid_q <= 1'b1;
          item_q  <= '{out_byte: len_w, byte_kind: KindLength, final_byte: 1'b0};
          idx_q   <= '0;
          slot_q  <= '0;
          state_q <= StRead;
        end
        StRead: begin
          ch_q    <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          if (idx_q >= cnt_q) begin
            ch_q <= 2'd3;
          end else if (ch_q == 2'd0) begin
            ch_q <= 2'd1;
          end else if (ch_q == 2'd1) begin
            ch_q <= 2'd2;
          end
          if ((idx_q >= cnt_q) || sts_i.div_done) begin
            idx_q <= idx_q + 1'b1;
            ch_q  <= '0;
            if (slot_q == 2'd2) begin
              slot_q  <= '0;
              state_q <= StChar;
            end else begin
              slot_q  <= slot_q + 1'b1;
              state_q <= StRead;
            end
          end
        end
        default: begin
          valid_q <= 1'b1;
          item_q  <= '{out_byte: ch_byte, byte_kind: KindText,
                       final_byte: (ch_q == 2'd3) && last_grp};
          ch_q    <= ch_q + 1'b1;
          if (ch_q == 2'd3) begin
            if (last_grp) begin
              state_q <= StIdle;
              cnt_q   <= '0;
              idx_q   <= '0;
            end else begin
              state_q <= StRead;
            end
          end
        end
      endcase
    end
  end

endmodule

[rtl/minmax_normalize_base64_encoder_core.sv]
// Channel  | Ports                               | Handshake
// input    | start_i, busy_o, in_item_i          | taken when start_i && !busy_o
// result   | out_valid_o, out_item_o             | each byte valid for one cycle, no stall
//
// A sample without line end is taken while busy_o stays low, as is a line end
// after overflow, which drops the line. On other line ends: count and length
// bytes, then per group of three samples read, start, 9-step restoring divider
// and done per stored sample, or a zero byte per missing one, then 4 text bytes.
// Reset clears the count, min/max and state; the sample store is not cleared.
// The receiver cannot stall; every result is shown for exactly one cycle.
module minmax_normalize_base64_encoder_core
  import mmb64_pkg::*;
#(
  parameter int unsigned MaxSamples = MaxSamplesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_item_t  in_item_i,
  output logic      busy_o,
  output logic      out_valid_o,
  output out_item_t out_item_o
);

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [CountW-1:0] wr_addr, rd_addr;
  logic [1:0]        slot;
  logic [23:0]       group;

  mmb64_ctrl #(.MaxSamples(MaxSamples)) u_ctrl (
    .clk_i, .rst_ni, .start_i,
    .line_end_i (in_item_i.line_end),
    .sts_i      (sts),
    .group_i    (group),
    .busy_o,
    .cmd_o      (cmd),
    .wr_addr_o  (wr_addr),
    .rd_addr_o  (rd_addr),
    .slot_o     (slot),
    .valid_o    (out_valid_o),
    .item_o     (out_item_o)
  );

  mmb64_datapath #(.MaxSamples(MaxSamples)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i     (cmd),
    .sample_i  (in_item_i.sample),
    .wr_addr_i (wr_addr),
    .rd_addr_i (rd_addr),
    .slot_i    (slot),
    .sts_o     (sts),
    .group_o   (group)
  );

endmodule

[rtl/mmb64_checker.sv]
module mmb64_checker
  import mmb64_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start_i,
  input logic      busy_o,
  input logic      out_valid_o,
  input out_item_t out_item_o
);

  // count byte opens every emitted line and is followed by the length byte
  a_len_after_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.byte_kind == KindCount |=>
      out_valid_o && out_item_o.byte_kind == KindLength)
    else $error("length byte missing");

  a_busy_on_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.final_byte |-> busy_o)
    else $error("result while idle");

  // the final byte is shown while the controller is already back to idle
  a_final_drops_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.final_byte |-> !busy_o)
    else $error("busy with final byte");

  a_final_is_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.final_byte |-> out_item_o.byte_kind == KindText)
    else $error("final byte not text");

endmodule

bind minmax_normalize_base64_encoder_core mmb64_checker u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .out_valid_o, .out_item_o
);

[verif/minmax_normalize_base64_encoder_core_checker.sv]
module minmax_normalize_base64_encoder_core_checker
  import mmb64_pkg::*;
#(
  parameter int unsigned MaxSamples = MaxSamplesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      busy_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        lines_emitted_o,
  output int        lines_dropped_o
);

  logic signed [31:0] line_buf [MaxSamples];
  int unsigned        line_len;
  logic signed [31:0] line_min;
  logic signed [31:0] line_max;
  logic               line_ovf;
  out_item_t          byte_queue [$];

  assign pending_o = byte_queue.size();

  function automatic logic [7:0] norm_byte(logic signed [31:0] v, logic signed [31:0] lo,
                                           logic signed [31:0] hi);
    logic [32:0] span;
    logic [32:0] off;
    logic [40:0] q;
    span = {1'b0, 32'(hi - lo)};
    off  = {1'b0, 32'(v - lo)};
    if (span == 0) begin
      q = 0;
    end else begin
      q = {off, 8'h00} / 41'(span);
    end
    if (q > 255) q = 255;
    return q[7:0] ^ 8'h80;
  endfunction

  function automatic logic [7:0] enc_char(logic [5:0] idx);
    if (idx < 26) return 8'd65 + 8'(idx);
    if (idx < 52) return 8'd97 + 8'(idx - 26);
    if (idx < 62) return 8'd48 + 8'(idx - 52);
    if (idx == 62) return 8'd43;
    return 8'd47;
  endfunction

  task automatic push_byte(logic [7:0] b, logic [1:0] kind);
    out_item_t r;
    r.out_byte = b;
    r.byte_kind = kind;
    r.final_byte = 1'b0;
    byte_queue.push_back(r);
  endtask

  task automatic clear_line();
    line_len = 0;
    line_min = 32'sh7FFFFFFF;
    line_max = 32'sh80000000;
    line_ovf = 1'b0;
  endtask

  task automatic accept_sample(in_item_t it);
    logic [7:0] b0, b1, b2;
    logic       has1, has2;
    if (line_len < MaxSamples) begin
      line_buf[line_len] = it.sample;
      line_len++;
      if (it.sample < line_min) line_min = it.sample;
      if (it.sample > line_max) line_max = it.sample;
    end else begin
      line_ovf = 1'b1;
    end
    if (!it.line_end) return;
    if (line_ovf) begin
      lines_dropped_o++;
      clear_line();
      return;
    end
    push_byte(8'(line_len), KindCount);
    push_byte(8'(4 * ((line_len + 2) / 3)), KindLength);
    for (int unsigned i = 0; i < line_len; i += 3) begin
      has1 = (i + 1) < line_len;
      has2 = (i + 2) < line_len;
      b0 = norm_byte(line_buf[i], line_min, line_max);
      b1 = has1 ? norm_byte(line_buf[i + 1], line_min, line_max) : 8'h00;
      b2 = has2 ? norm_byte(line_buf[i + 2], line_min, line_max) : 8'h00;
      push_byte(enc_char(b0[7:2]), KindText);
      push_byte(enc_char({b0[1:0], b1[7:4]}), KindText);
      push_byte(has1 ? enc_char({b1[3:0], b2[7:6]}) : PadChar, KindText);
      push_byte(has2 ? enc_char(b2[5:0]) : PadChar, KindText);
    end
    byte_queue[$].final_byte = 1'b1;
    lines_emitted_o++;
    clear_line();
  endtask

  initial begin
    fail_count_o = 0;
    lines_emitted_o = 0;
    lines_dropped_o = 0;
    clear_line();
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_i) begin
        if (byte_queue.size() == 0) begin
          $error("unexpected transaction: byte %h", out_item_i.out_byte);
          fail_count_o++;
        end else begin
          want = byte_queue.pop_front();
          if (out_item_i.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, actual %h", want.out_byte, out_item_i.out_byte);
            fail_count_o++;
          end
          if (out_item_i.byte_kind !== want.byte_kind) begin
            $error("byte_kind: expected %0d, actual %0d", want.byte_kind,
                   out_item_i.byte_kind);
            fail_count_o++;
          end
          if (out_item_i.final_byte !== want.final_byte) begin
            $error("final_byte: expected %0d, actual %0d", want.final_byte,
                   out_item_i.final_byte);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) accept_sample(in_item_i);
    end
  end

endmodule

[verif/minmax_normalize_base64_encoder_core_test.sv]
module minmax_normalize_base64_encoder_core_test;
  import mmb64_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  in_item_t  in_item_i = '0;
  logic      busy_o;
  logic      out_valid_o;
  out_item_t out_item_o;
  int        fail_count;
  int        pending;
  int        lines_emitted;
  int        lines_dropped;
  int        sent;

  always #4 clk_i = ~clk_i;

  minmax_normalize_base64_encoder_core u_dut (
    .clk_i, .rst_ni, .start_i, .in_item_i, .busy_o, .out_valid_o, .out_item_o
  );

  minmax_normalize_base64_encoder_core_checker u_chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_item_i(out_item_o),
    .fail_count_o(fail_count), .pending_o(pending),
    .lines_emitted_o(lines_emitted), .lines_dropped_o(lines_dropped)
  );

  // Present one transaction, hold until taken, then drop start.
  task automatic send_sample(logic signed [31:0] v, logic last, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
    repeat (gap) @(negedge clk_i);
    in_item_i.sample = v;
    in_item_i.line_end = last;
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    start_i = 1'b0;
    sent++;
  endtask

  function automatic logic signed [31:0] rand_sample(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 1000) - 500;
      2: return $urandom_range(0, 3) == 0 ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return 32'($urandom_range(0, 7)) << $urandom_range(0, 28);
    endcase
  endfunction

  task automatic send_line(int len, int mode, bit burst = 0);
    for (int i = 0; i < len; i++) begin
      send_sample(rand_sample(mode), i == len - 1, burst);
    end
  endtask

  initial begin
    sent = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    // Directed: extremes, flat line, full scale, single sample, short groups.
    send_sample(32'sh80000000, 1'b0);
    send_sample(32'sh7FFFFFFF, 1'b0);
    send_sample(32'sh00000000, 1'b1);
    send_sample(32'sh12345678, 1'b1);
    send_sample(-5, 1'b0);
    send_sample(-5, 1'b0);
    send_sample(-5, 1'b0);
    send_sample(-5, 1'b1);
    send_sample(10, 1'b0);
    send_sample(20, 1'b1);
    send_sample(32'shFFFFFFFF, 1'b0);
    send_sample(32'h55555555, 1'b0);
    send_sample(32'hAAAAAAAA, 1'b1);
    send_line(32, 0, 1'b1);
    wait (pending == 0);
    // Overflowing lines are dropped.
    send_line(33, 1);
    send_line(40, 3);
    while (sent < 470) begin
      case ($urandom_range(0, 9))
        0: send_line($urandom_range(33, 40), $urandom_range(0, 3));
        1: send_line(32, $urandom_range(0, 3), 1'b1);
        default: send_line($urandom_range(1, 12), $urandom_range(0, 3),
                           $urandom_range(0, 4) == 0);
      endcase
      if ($urandom_range(0, 15) == 0) wait (pending == 0);
    end
    wait (pending == 0);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d samples: %0d lines encoded, %0d overlong lines dropped.",
             sent, lines_emitted, lines_dropped);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
